### rtl/bhpq_pkg.sv
// Shared types, constants and the ordering function of the binary heap priority queue.
// No dependencies; imported by bhpq_ctrl, bhpq_dp, the core and the bench (not by bhpq_ram).
`default_nettype none

package bhpq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_WAIT,
        S_POP_CHK0,
        S_POP_LAST,
        S_SINK_CHK,
        S_SINK_L,
        S_SINK_R,
        S_SINK_CMP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_PARENT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_VAL,
        WR_RD,
        WR_CAND
    } t_wr_sel;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_COUNT,
        POS_ZERO,
        POS_PARENT,
        POS_CAND
    } t_pos_sel;

    typedef enum logic [1:0] {
        CAND_HOLD,
        CAND_LEFT,
        CAND_RIGHT
    } t_cand_sel;

    typedef struct packed {
        logic      val_in;
        logic      val_rd;
        t_pos_sel  pos_sel;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      wr_en;
        t_wr_sel   wr_sel;
        t_cand_sel cand_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      st_wr;
        t_status   st_val;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic child_none;
        logic right_exists;
        logic val_before_rd;
        logic rd_before_cand;
        logic cand_before_val;
    } t_dp_sts;

    function automatic logic ordered_before(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic                     min_order
    );
        if (min_order) begin
            return a < b;
        end
        return a > b;
    endfunction

endpackage

`default_nettype wire

### rtl/bhpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/bhpq_ctrl.sv
// Heap controller: sequences push sift-up, pop sift-down and result handshake.
// Depends on bhpq_pkg; drives bhpq_dp through t_dp_cmd, reads t_dp_sts.
`default_nettype none

module bhpq_ctrl import bhpq_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    input  wire logic    i_op,
    input  wire logic    i_m_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_s_ready,
    output logic         o_m_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    if (i_op == OP_POP) begin
                        n_state = i_sts.empty ? S_OUT : S_POP_CHK0;
                    end else begin
                        n_state = i_sts.full ? S_OUT : S_PUSH_CHK;
                    end
                end
            end
            S_PUSH_CHK:  n_state = i_sts.pos_zero ? S_OUT : S_PUSH_WAIT;
            S_PUSH_WAIT: n_state = i_sts.val_before_rd ? S_PUSH_CHK : S_OUT;
            S_POP_CHK0:  n_state = i_sts.empty ? S_OUT : S_POP_LAST;
            S_POP_LAST:  n_state = S_SINK_CHK;
            S_SINK_CHK:  n_state = i_sts.child_none ? S_OUT : S_SINK_L;
            S_SINK_L:    n_state = i_sts.right_exists ? S_SINK_R : S_SINK_CMP;
            S_SINK_R:    n_state = S_SINK_CMP;
            S_SINK_CMP:  n_state = i_sts.cand_before_val ? S_SINK_CHK : S_OUT;
            S_OUT:       n_state = i_m_ready ? S_IDLE : S_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.val_in   = 1'b0;
        o_cmd.val_rd   = 1'b0;
        o_cmd.pos_sel  = POS_HOLD;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_sel   = RD_PARENT;
        o_cmd.wr_en    = 1'b0;
        o_cmd.wr_sel   = WR_VAL;
        o_cmd.cand_sel = CAND_HOLD;
        o_cmd.cnt_inc  = 1'b0;
        o_cmd.cnt_dec  = 1'b0;
        o_cmd.st_wr    = 1'b0;
        o_cmd.st_val   = ST_OK;
        o_s_ready      = 1'b0;
        o_m_valid      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.st_wr = 1'b1;
                    if (i_op == OP_POP) begin
                        if (i_sts.empty) begin
                            o_cmd.st_val = ST_EMPTY;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end else begin
                        if (i_sts.full) begin
                            o_cmd.st_val = ST_FULL;
                        end else begin
                            o_cmd.val_in  = 1'b1;
                            o_cmd.pos_sel = POS_COUNT;
                        end
                    end
                end
            end
            S_PUSH_CHK: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PARENT;
                end
            end
            S_PUSH_WAIT: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.val_before_rd) begin
                    o_cmd.wr_sel  = WR_RD;
                    o_cmd.pos_sel = POS_PARENT;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_POP_CHK0: begin
                if (!i_sts.empty) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_LAST;
                    o_cmd.pos_sel = POS_ZERO;
                end
            end
            S_POP_LAST: begin
                o_cmd.val_rd = 1'b1;
            end
            S_SINK_CHK: begin
                if (i_sts.child_none) begin
                    o_cmd.wr_en = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LEFT;
                end
            end
            S_SINK_L: begin
                o_cmd.cand_sel = CAND_LEFT;
                if (i_sts.right_exists) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_RIGHT;
                end
            end
            S_SINK_R: begin
                if (i_sts.rd_before_cand) begin
                    o_cmd.cand_sel = CAND_RIGHT;
                end
            end
            S_SINK_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.cand_before_val) begin
                    o_cmd.wr_sel  = WR_CAND;
                    o_cmd.pos_sel = POS_CAND;
                end
            end
            S_OUT: begin
                o_m_valid = 1'b1;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/bhpq_dp.sv
// Heap datapath: heap RAM, slot index, moving value, child candidate, count and order bit.
// Depends on bhpq_pkg and bhpq_ram; commanded by bhpq_ctrl.
`default_nettype none

module bhpq_dp import bhpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [DATA_W-1:0] i_value,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_data,
    output logic      [DATA_W-1:0] o_top_value,
    output logic      [COUNT_W-1:0] o_count,
    output logic                   o_is_empty,
    output t_status                o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    logic [CW-1:0]     r_cnt;
    logic              r_min;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_cidx, n_cidx;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_cand, n_cand;
    logic [DATA_W-1:0] r_top;
    t_status           r_status;

    logic [AW-1:0]     w_parent, w_left_a, w_right_a, w_raddr;
    logic [XW-1:0]     w_left_x, w_right_x, w_cnt_x;
    logic [DATA_W-1:0] w_rdata, w_wdata;

    assign w_parent  = (r_pos - AW'(1)) >> 1;
    assign w_left_x  = {1'b0, r_pos, 1'b1};
    assign w_right_x = w_left_x + XW'(1);
    assign w_cnt_x   = XW'(r_cnt);
    assign w_left_a  = w_left_x[AW-1:0];
    assign w_right_a = w_right_x[AW-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PARENT: w_raddr = w_parent;
            RD_LAST:   w_raddr = AW'(r_cnt);
            RD_LEFT:   w_raddr = w_left_a;
            RD_RIGHT:  w_raddr = w_right_a;
            default:   w_raddr = w_parent;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_VAL:  w_wdata = r_val;
            WR_RD:   w_wdata = w_rdata;
            WR_CAND: w_wdata = r_cand;
            default: w_wdata = r_val;
        endcase
    end

    bhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (i_cmd.pos_sel)
            POS_HOLD:   n_pos = r_pos;
            POS_COUNT:  n_pos = AW'(r_cnt);
            POS_ZERO:   n_pos = '0;
            POS_PARENT: n_pos = w_parent;
            POS_CAND:   n_pos = r_cidx;
            default:    n_pos = r_pos;
        endcase
    end

    always_comb begin
        n_val = r_val;
        if (i_cmd.val_in) begin
            n_val = i_value;
        end else if (i_cmd.val_rd) begin
            n_val = w_rdata;
        end
    end

    always_comb begin
        n_cand = r_cand;
        n_cidx = r_cidx;
        unique case (i_cmd.cand_sel)
            CAND_HOLD: begin
                n_cand = r_cand;
            end
            CAND_LEFT: begin
                n_cand = w_rdata;
                n_cidx = w_left_a;
            end
            CAND_RIGHT: begin
                n_cand = w_rdata;
                n_cidx = w_right_a;
            end
            default: begin
                n_cand = r_cand;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_min <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_cand <= n_cand;
        r_cidx <= n_cidx;
        if (i_cmd.wr_en && (r_pos == '0)) begin
            r_top <= w_wdata;
        end
        if (i_cmd.st_wr) begin
            r_status <= i_cmd.st_val;
        end
    end

    assign o_sts.full            = (r_cnt == CW'(CAPACITY));
    assign o_sts.empty           = (r_cnt == '0);
    assign o_sts.pos_zero        = (r_pos == '0);
    assign o_sts.child_none      = (w_left_x >= w_cnt_x);
    assign o_sts.right_exists    = (w_right_x < w_cnt_x);
    assign o_sts.val_before_rd   = ordered_before(r_val, w_rdata, r_min);
    assign o_sts.rd_before_cand  = ordered_before(w_rdata, r_cand, r_min);
    assign o_sts.cand_before_val = ordered_before(r_cand, r_val, r_min);

    assign o_top_value = (r_cnt == '0) ? '0 : r_top;
    assign o_count     = COUNT_W'(r_cnt);
    assign o_is_empty  = (r_cnt == '0);
    assign o_status    = r_status;

endmodule

`default_nettype wire

### rtl/binary_heap_priority_queue_core.sv
// A push rises level by level until it reaches the root or no longer ranks above its parent;
// a pop sinks level by level, reading the right child only when it exists, until it has no
// child left or its better child does not rank above the moving value.
// A refused request or a pop that empties the heap goes to the result without moving a value.
// Only one request is in flight; the next is taken once the result has been accepted.
// Reset (synchronous, active low) empties the heap and selects max ordering.
`default_nettype none

module binary_heap_priority_queue_core import bhpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] value
    input  wire logic                 s_axis_tuser,   // [0] operation
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] top_value, [37:32] count,
                                                      // [38] is_empty, [40:39] status
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_data      // min_order
);

    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    logic [DATA_W-1:0]  w_top_value;
    logic [COUNT_W-1:0] w_count;
    logic               w_is_empty;
    t_status            w_status;

    assign o_cfg_ready = 1'b1;

    bhpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_op      (s_axis_tuser),
        .i_m_ready (m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid)
    );

    bhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_top_value (w_top_value),
        .o_count     (w_count),
        .o_is_empty  (w_is_empty),
        .o_status    (w_status)
    );

    assign m_axis_tdata = {
        (M_TDATA_W - DATA_W - COUNT_W - 1 - STATUS_W)'(0),
        w_status,
        w_is_empty,
        w_count,
        w_top_value
    };

`ifndef ASSERT_OFF
    a_busy_or_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output stages active together");

    a_inc_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cnt_inc |-> !w_sts.full)
        else $error("count incremented while full");

    a_dec_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cnt_dec |-> !w_sts.empty)
        else $error("count decremented while empty");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new request taken right after accept");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for binary_heap_priority_queue_core: push/pop requests in both orderings,
// results compared field by field against an in-bench heap predictor or, for typed directed rows, fixed values.
// Depends on bhpq_pkg and the core RTL only.
module tb_top import bhpq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH   = 32;
    localparam int DIRECTED_N   = 22;
    localparam int RANDOM_ITEMS = 700;
    localparam int SETTLE_WAIT  = 40;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic signed [DATA_W-1:0]  top;
        logic        [COUNT_W-1:0] count;
        logic                      empty;
        t_status                   status;
    } t_heap_result;

    typedef struct packed {
        t_op                 op;
        logic [DATA_W-1:0]   value;
        logic                typed;
        t_heap_result        want;
    } t_stim_row;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_MOSTLY,
        RX_BURSTY
    } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;   // [31:0] value
    logic                 s_axis_tuser = 1'b0; // [0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [31:0] top_value, [37:32] count,
                                               // [38] is_empty, [40:39] status
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_data = 1'b0;

    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int                       heap_count = 0;
    logic                     heap_min_order = 1'b0;

    t_heap_result pending_results [$];
    t_stim_row    directed_rows [DIRECTED_N];

    int       error_count = 0;
    int       items_sent = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       gap_max = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    bit       hold_start = 1'b0;
    int       hold_left = 0;
    int       rx_run = 0;
    bit       rx_on = 1'b1;
    t_heap_result rx_got, rx_want;

    binary_heap_priority_queue_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit ranks_above(logic signed [DATA_W-1:0] a,
                                       logic signed [DATA_W-1:0] b);
        if (heap_min_order) begin
            return a < b;
        end
        return a > b;
    endfunction

    function automatic t_heap_result heap_apply(t_op op, logic signed [DATA_W-1:0] v);
        t_heap_result r;
        int pos;
        int parent;
        int child;
        logic signed [DATA_W-1:0] moved;
        r.status = ST_OK;
        if (op == OP_PUSH) begin
            if (heap_count >= HEAP_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_count;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!ranks_above(v, heap_mem[parent])) break;
                    heap_mem[pos] = heap_mem[parent];
                    pos = parent;
                end
                heap_mem[pos] = v;
                heap_count++;
            end
        end else begin
            if (heap_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                heap_count--;
                if (heap_count > 0) begin
                    moved = heap_mem[heap_count];
                    pos = 0;
                    while (1'b1) begin
                        child = 2 * pos + 1;
                        if (child >= heap_count) break;
                        if (child + 1 < heap_count &&
                            ranks_above(heap_mem[child + 1], heap_mem[child])) begin
                            child = child + 1;
                        end
                        if (!ranks_above(heap_mem[child], moved)) break;
                        heap_mem[pos] = heap_mem[child];
                        pos = child;
                    end
                    heap_mem[pos] = moved;
                end
            end
        end
        r.top   = (heap_count > 0) ? heap_mem[0] : '0;
        r.count = heap_count[COUNT_W-1:0];
        r.empty = (heap_count == 0);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'($signed($urandom_range(0, 6)) - 3);
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_op op, input logic [DATA_W-1:0] value,
                                input logic typed, input t_heap_result want);
        t_heap_result predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = heap_apply(op, value);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_order(input logic min_order);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= min_order;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        heap_min_order = min_order;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_got.top    = m_axis_tdata[31:0];
            rx_got.count  = m_axis_tdata[37:32];
            rx_got.empty  = m_axis_tdata[38];
            rx_got.status = t_status'(m_axis_tdata[40:39]);
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, top %0d count %0d", $time,
                         rx_got.top, rx_got.count);
            end else begin
                rx_want = pending_results.pop_front();
                if (rx_got.top !== rx_want.top) begin
                    error_count++;
                    $display("%0t: top_value expected %0d actual %0d", $time,
                             rx_want.top, rx_got.top);
                end
                if (rx_got.count !== rx_want.count) begin
                    error_count++;
                    $display("%0t: count expected %0d actual %0d", $time,
                             rx_want.count, rx_got.count);
                end
                if (rx_got.empty !== rx_want.empty) begin
                    error_count++;
                    $display("%0t: is_empty expected %0b actual %0b", $time,
                             rx_want.empty, rx_got.empty);
                end
                if (rx_got.status !== rx_want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             rx_want.status, rx_got.status);
                end
            end
        end
        if (hold_start) begin
            hold_left  = LONG_HOLD;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: begin
                    if (rx_run == 0) begin
                        rx_on  = !rx_on;
                        rx_run = $urandom_range(1, 8);
                    end
                    rx_run--;
                    m_axis_tready <= rx_on;
                end
            endcase
        end
    end

    initial begin
        int k;
        int phase;
        int run_len;
        int ops_left;
        t_op run_op;
        t_op op;
        t_heap_result none;
        none = '0;
        directed_rows = '{
            '{OP_POP,  32'h0000_0000, 1'b1, '{32'sh0000_0000, 6'd0, 1'b1, ST_EMPTY}},
            '{OP_PUSH, 32'h8000_0000, 1'b1, '{32'sh8000_0000, 6'd1, 1'b0, ST_OK}},
            '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 6'd2, 1'b0, ST_OK}},
            '{OP_PUSH, 32'h0000_0000, 1'b1, '{32'sh7FFF_FFFF, 6'd3, 1'b0, ST_OK}},
            '{OP_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 6'd4, 1'b0, ST_OK}},
            '{OP_PUSH, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_PUSH, 32'h0000_0005, 1'b0, '0},
            '{OP_PUSH, 32'h0000_0005, 1'b0, '0},
            '{OP_PUSH, 32'hAAAA_AAAA, 1'b0, '0},
            '{OP_PUSH, 32'h5555_5555, 1'b0, '0},
            '{OP_POP,  32'hFFFF_FFFF, 1'b0, '0},
            '{OP_POP,  32'h1234_5678, 1'b0, '0},
            '{OP_POP,  32'h8000_0000, 1'b0, '0},
            '{OP_POP,  32'h0000_0000, 1'b0, '0},
            '{OP_POP,  32'h7FFF_FFFF, 1'b0, '0},
            '{OP_POP,  32'h5555_5555, 1'b0, '0},
            '{OP_POP,  32'hAAAA_AAAA, 1'b0, '0},
            '{OP_POP,  32'h0000_0001, 1'b0, '0},
            '{OP_POP,  32'h0000_0000, 1'b0, '0},
            '{OP_POP,  32'hFFFF_FFFF, 1'b1, '{32'sh0000_0000, 6'd0, 1'b1, ST_EMPTY}},
            '{OP_PUSH, 32'h0000_0001, 1'b1, '{32'sh0000_0001, 6'd1, 1'b0, ST_OK}},
            '{OP_POP,  32'h8000_0000, 1'b1, '{32'sh0000_0000, 6'd0, 1'b1, ST_OK}}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_order(1'b0);
        gap_max = 4;
        rx_mode = RX_RANDOM;
        for (k = 0; k < DIRECTED_N; k++) begin
            send_request(directed_rows[k].op, directed_rows[k].value,
                         directed_rows[k].typed, directed_rows[k].want);
        end

        // flip ordering with a partly filled heap, then overfill and overdrain
        for (k = 0; k < 10; k++) send_request(OP_PUSH, pick_value(), 1'b0, none);
        set_order(1'b1);
        rx_mode = RX_BURSTY;
        for (k = 0; k < HEAP_DEPTH - 8; k++) send_request(OP_PUSH, pick_value(), 1'b0, none);
        for (k = 0; k < HEAP_DEPTH + 2; k++) send_request(OP_POP, pick_value(), 1'b0, none);

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            set_order(1'($urandom_range(0, 1)));
            gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
            rx_mode = t_rx_mode'(phase % 4);
            if (phase == 1) begin
                gap_max    = 0;
                hold_start = 1'b1;
            end
            ops_left = 60;
            while (ops_left > 0) begin
                run_op  = t_op'($urandom_range(0, 1));
                run_len = (run_op == OP_PUSH) ? $urandom_range(1, 40) : $urandom_range(1, 30);
                for (k = 0; k < run_len && ops_left > 0; k++) begin
                    op = run_op;
                    if ($urandom_range(0, 9) == 0) begin
                        op = (run_op == OP_PUSH) ? OP_POP : OP_PUSH;
                    end
                    send_request(op, pick_value(), 1'b0, none);
                    ops_left--;
                end
            end
            phase++;
        end

        drain();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
